@@ rtl/core/mnva_pkg.sv @@
`default_nettype none
package mnva_pkg;

   localparam int IDX_W            = 10;      // vertex index width
   localparam int POS_W            = 16;      // Q8.8 coordinate
   localparam int NRM_W            = 16;      // Q1.14 normal component
   localparam int CNT_W            = 16;      // seen count
   localparam int VEC_W            = 36;      // raw vector fed to the normalizer
   localparam int VERTEX_COUNT_DEF = 1024;
   localparam int Q14_ONE          = 16384;
   localparam int COUNT_MAX        = 65535;
   localparam int REQ_DATA_W       = 80;
   localparam int RSP_DATA_W       = 64;

   typedef enum logic [1:0] {CMD_LOAD, CMD_CLEAR, CMD_TRI, CMD_READ} cmd_type;
   typedef enum logic [1:0] {ST_OK, ST_DEGEN, ST_RANGE} status_type;

   typedef struct packed {
      logic                        start;
      logic [2:0][VEC_W-1:0]       vec;
   } norm_req_type;

   typedef struct packed {
      logic                        done;
      logic                        zero;
      logic [2:0][NRM_W-1:0]       comp;
   } norm_rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/mesh_vertex_normal_averager.sv @@
`default_nettype none
// Vertex normal averager. One command beat enters on req_*, one result beat
// leaves on rsp_* for every command, in order.
//   req_tuser : command (load position, clear, triangle, read normal)
//   rsp_tuser : status (ok, degenerate face skipped, index out of range)
// A triangle forms the unit face normal of (b-a)x(c-a), returns it, and
// folds it into the stored normal and count of a, b and c in that order.
// A triangle runs the shared normalizer once for the face normal and once
// more for each vertex that blends; its work dominates the command time:
// at most 4 scaling shifts here, 4 squaring steps, a 31-step bitwise root
// and three 15-step restoring divides. One command is in work at a time;
// req_tready is high only while the sequencer is idle.
// Results sit in an output register, so a stalled receiver holds only the
// finish of the next command; the block still takes that command in.
// After reset the normal/count table, DEPTH = min(VERTEX_COUNT, 1024)
// entries, is swept to zero with req_tready low. Positions are not
// cleared and read as garbage until loaded.
module mesh_vertex_normal_averager
   import mnva_pkg::*;
#(
   parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // vert_a[9:0], vert_b[19:10], vert_c[29:20], pos_x[45:30],
   // pos_y[61:46], pos_z[77:62], zero pad[79:78]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]            req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // norm_x[15:0], norm_y[31:16], norm_z[47:32], seen_count[63:48]
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output      logic [1:0]            rsp_tuser
);

   localparam int DEPTH = (VERTEX_COUNT < (1 << IDX_W)) ? VERTEX_COUNT : (1 << IDX_W);
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_CMD, S_RDW, T_RDB, T_RDC, T_RDD, T_MUL, T_FNS, T_FNW,
      V_RD, V_DAT, V_MUL, V_NS, V_NW, S_FIN
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic                     clr_cmd_ff, clr_cmd_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [IDX_W-1:0]         va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in;
   logic [3*POS_W-1:0]       pos_ff, pos_in;
   logic [2:0][POS_W-1:0]    pa_ff, pa_in;
   logic [2:0][POS_W:0]      d1_ff, d1_in, d2_ff, d2_in;
   logic [2:0]               step_ff, step_in;
   logic [2*POS_W+1:0]       prod_ff, prod_in;
   logic [VEC_W-1:0]         acc_ff, acc_in;
   logic [2:0][VEC_W-1:0]    vec_ff, vec_in;
   logic [2:0][NRM_W-1:0]    face_ff, face_in;
   logic [1:0]               vk_ff, vk_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [2:0][NRM_W-1:0]    nor_ff, nor_in;
   logic [2:0][NRM_W-1:0]    res_nrm_ff, res_nrm_in;
   logic [CNT_W-1:0]         res_cnt_ff, res_cnt_in;
   status_type               res_st_ff, res_st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;

   // memories
   logic                     pos_we;
   logic [AW-1:0]            pos_raddr;
   logic [2:0][POS_W-1:0]    pos_rdata;
   logic                     vtx_we;
   logic [AW-1:0]            vtx_waddr;
   logic [RSP_DATA_W-1:0]    vtx_wdata;
   logic [AW-1:0]            vtx_raddr;
   logic [RSP_DATA_W-1:0]    vtx_rdata;

   // multiplier operands
   logic [POS_W:0]           mul_a, mul_b;

   logic [IDX_W-1:0]         vsel;
   logic [CNT_W-1:0]         rd_cnt;
   logic [CNT_W-1:0]         n_new;
   logic [CNT_W-1:0]         nm1;
   logic [2:0][NRM_W-1:0]    blend_r;
   logic                     accept;
   logic                     out_free;

   norm_req_type             nreq;
   norm_rsp_type             nrsp;

   function automatic logic out_of_range(input logic [IDX_W-1:0] idx);
      return 32'(idx) >= 32'(VERTEX_COUNT);
   endfunction

   mnva_ram #(.WIDTH(3*POS_W), .DEPTH(DEPTH)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (va_ff[AW-1:0]),
      .wdata (pos_ff),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   // {count, nz, ny, nx}
   mnva_ram #(.WIDTH(RSP_DATA_W), .DEPTH(DEPTH)) u_vtx_ram (
      .clock (clock),
      .we    (vtx_we),
      .waddr (vtx_waddr),
      .wdata (vtx_wdata),
      .raddr (vtx_raddr),
      .rdata (vtx_rdata)
   );

   mnva_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rsp   (nrsp)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign nreq.start = (state_ff == T_FNS) || (state_ff == V_NS);
   assign nreq.vec   = vec_ff;

   always_comb begin
      case (vk_ff)
         2'd0:    vsel = va_ff;
         2'd1:    vsel = vb_ff;
         default: vsel = vc_ff;
      endcase
   end

   assign rd_cnt  = vtx_rdata[RSP_DATA_W-1 -: CNT_W];
   assign n_new   = (rd_cnt == CNT_W'(COUNT_MAX)) ? rd_cnt : rd_cnt + 1'b1;
   assign nm1     = cnt_ff - 1'b1;
   // cancelling blend falls back to the face normal
   assign blend_r = nrsp.zero ? face_ff : nrsp.comp;

   // shared 17x17 signed multiplier, registered product
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == T_MUL) begin
         case (step_ff)
            3'd0: begin mul_a = d1_ff[1]; mul_b = d2_ff[2]; end
            3'd1: begin mul_a = d1_ff[2]; mul_b = d2_ff[1]; end
            3'd2: begin mul_a = d1_ff[2]; mul_b = d2_ff[0]; end
            3'd3: begin mul_a = d1_ff[0]; mul_b = d2_ff[2]; end
            3'd4: begin mul_a = d1_ff[0]; mul_b = d2_ff[1]; end
            3'd5: begin mul_a = d1_ff[1]; mul_b = d2_ff[0]; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         case (step_ff[1:0])
            2'd0:    mul_a = {nor_ff[0][NRM_W-1], nor_ff[0]};
            2'd1:    mul_a = {nor_ff[1][NRM_W-1], nor_ff[1]};
            2'd2:    mul_a = {nor_ff[2][NRM_W-1], nor_ff[2]};
            default: mul_a = '0;
         endcase
         mul_b = {1'b0, nm1};
      end
   end

   assign prod_in = $signed(mul_a) * $signed(mul_b);

   assign pos_raddr = (state_ff == T_RDB) ? vb_ff[AW-1:0] :
                      (state_ff == T_RDC) ? vc_ff[AW-1:0] : va_ff[AW-1:0];
   assign vtx_raddr = (state_ff == V_RD) ? vsel[AW-1:0] : va_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_cmd_in   = clr_cmd_ff;
      cmd_in       = cmd_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      pos_in       = pos_ff;
      pa_in        = pa_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      vec_in       = vec_ff;
      face_in      = face_ff;
      vk_in        = vk_ff;
      cnt_in       = cnt_ff;
      nor_in       = nor_ff;
      res_nrm_in   = res_nrm_ff;
      res_cnt_in   = res_cnt_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      pos_we       = 1'b0;
      vtx_we       = 1'b0;
      vtx_waddr    = vsel[AW-1:0];
      vtx_wdata    = '0;

      case (state_ff)
         S_CLR: begin
            vtx_we    = 1'b1;
            vtx_waddr = clr_ff;
            if (clr_ff == AW'(DEPTH - 1)) begin
               clr_in = '0;
               if (clr_cmd_ff) begin
                  res_nrm_in = '0;
                  res_cnt_in = '0;
                  res_st_in  = ST_OK;
                  state_in   = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_tuser);
               va_in    = req_tdata[IDX_W-1:0];
               vb_in    = req_tdata[2*IDX_W-1:IDX_W];
               vc_in    = req_tdata[3*IDX_W-1:2*IDX_W];
               pos_in   = req_tdata[3*IDX_W+3*POS_W-1:3*IDX_W];
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            res_nrm_in = '0;
            res_cnt_in = '0;
            res_st_in  = ST_OK;
            case (cmd_ff)
               CMD_LOAD: begin
                  if (out_of_range(va_ff)) begin
                     res_st_in = ST_RANGE;
                  end else begin
                     pos_we = 1'b1;
                  end
                  state_in = S_FIN;
               end
               CMD_CLEAR: begin
                  clr_in     = '0;
                  clr_cmd_in = 1'b1;
                  state_in   = S_CLR;
               end
               CMD_READ: begin
                  if (out_of_range(va_ff)) begin
                     res_st_in = ST_RANGE;
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_RDW;
                  end
               end
               CMD_TRI: begin
                  if (out_of_range(va_ff) || out_of_range(vb_ff) || out_of_range(vc_ff)) begin
                     res_st_in = ST_RANGE;
                     state_in  = S_FIN;
                  end else begin
                     state_in = T_RDB;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_RDW: begin
            res_nrm_in = vtx_rdata[3*NRM_W-1:0];
            res_cnt_in = rd_cnt;
            state_in   = S_FIN;
         end
         T_RDB: begin
            pa_in    = pos_rdata;
            state_in = T_RDC;
         end
         T_RDC: begin
            for (int i = 0; i < 3; i++) begin
               d1_in[i] = {pos_rdata[i][POS_W-1], pos_rdata[i]} -
                          {pa_ff[i][POS_W-1], pa_ff[i]};
            end
            state_in = T_RDD;
         end
         T_RDD: begin
            for (int i = 0; i < 3; i++) begin
               d2_in[i] = {pos_rdata[i][POS_W-1], pos_rdata[i]} -
                          {pa_ff[i][POS_W-1], pa_ff[i]};
            end
            step_in  = '0;
            state_in = T_MUL;
         end
         T_MUL: begin
            // even products open a component, odd ones close it
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd1, 3'd3, 3'd5: acc_in = {{2{prod_ff[2*POS_W+1]}}, prod_ff};
               3'd2: vec_in[0] = acc_ff - {{2{prod_ff[2*POS_W+1]}}, prod_ff};
               3'd4: vec_in[1] = acc_ff - {{2{prod_ff[2*POS_W+1]}}, prod_ff};
               3'd6: begin
                  vec_in[2] = acc_ff - {{2{prod_ff[2*POS_W+1]}}, prod_ff};
                  state_in  = T_FNS;
               end
               default: acc_in = acc_ff;
            endcase
         end
         T_FNS: begin
            state_in = T_FNW;
         end
         T_FNW: begin
            if (nrsp.done) begin
               if (nrsp.zero) begin
                  res_st_in = ST_DEGEN;
                  state_in  = S_FIN;
               end else begin
                  face_in  = nrsp.comp;
                  vk_in    = '0;
                  state_in = V_RD;
               end
            end
         end
         V_RD: begin
            state_in = V_DAT;
         end
         V_DAT: begin
            cnt_in = n_new;
            nor_in = vtx_rdata[3*NRM_W-1:0];
            if (n_new == CNT_W'(1)) begin
               // first sighting: take the face normal as is
               vtx_we    = 1'b1;
               vtx_wdata = {n_new, face_ff};
               if (vk_ff == 2'd2) begin
                  res_nrm_in = face_ff;
                  state_in   = S_FIN;
               end else begin
                  vk_in    = vk_ff + 1'b1;
                  state_in = V_RD;
               end
            end else begin
               step_in  = '0;
               state_in = V_MUL;
            end
         end
         V_MUL: begin
            // nor*(n-1) + face, one component a cycle
            step_in = step_ff + 1'b1;
            if (step_ff != '0) begin
               vec_in[step_ff[1:0] - 2'd1] =
                  {{2{prod_ff[2*POS_W+1]}}, prod_ff} +
                  {{(VEC_W-NRM_W){face_ff[step_ff[1:0] - 2'd1][NRM_W-1]}},
                   face_ff[step_ff[1:0] - 2'd1]};
            end
            if (step_ff == 3'd3) begin
               state_in = V_NS;
            end
         end
         V_NS: begin
            state_in = V_NW;
         end
         V_NW: begin
            if (nrsp.done) begin
               vtx_we    = 1'b1;
               vtx_wdata = {cnt_ff, blend_r};
               if (vk_ff == 2'd2) begin
                  res_nrm_in = face_ff;
                  state_in   = S_FIN;
               end else begin
                  vk_in    = vk_ff + 1'b1;
                  state_in = V_RD;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_cnt_ff, res_nrm_ff};
               rsp_user_in  = res_st_ff;
               clr_cmd_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      vc_ff       <= vc_in;
      pos_ff      <= pos_in;
      pa_ff       <= pa_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      vec_ff      <= vec_in;
      face_ff     <= face_in;
      vk_ff       <= vk_in;
      cnt_ff      <= cnt_in;
      nor_ff      <= nor_in;
      res_nrm_ff  <= res_nrm_in;
      res_cnt_ff  <= res_cnt_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

@@ rtl/core/mnva_ram.sv @@
`default_nettype none
module mnva_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(DEPTH)-1:0]   waddr,
   input  wire logic [WIDTH-1:0]           wdata,
   input  wire logic [$clog2(DEPTH)-1:0]   raddr,
   output      logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ rtl/core/mnva_norm.sv @@
`default_nettype none
// Iterative vector normalizer: scale down, sum of squares, bitwise root,
// then three restoring divisions giving round(mag * 16384 / len).
module mnva_norm
   import mnva_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire norm_req_type req,
   output      norm_rsp_type rsp
);

   typedef enum logic [2:0] {
      N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE
   } nstate_type;

   nstate_type              state_ff, state_in;
   logic [2:0][VEC_W-1:0]   mag_ff, mag_in;
   logic [2:0]              neg_ff, neg_in;
   logic                    zero_ff, zero_in;
   logic [1:0]              sel_ff, sel_in;
   logic [4:0]              step_ff, step_in;
   logic [59:0]             prod_ff, prod_in;
   logic [61:0]             sum_ff, sum_in;
   logic [61:0]             rad_ff, rad_in;
   logic [32:0]             rem_ff, rem_in;
   logic [30:0]             root_ff, root_in;
   logic [45:0]             num_ff, num_in;
   logic [45:0]             dsh_ff, dsh_in;
   logic [14:0]             quo_ff, quo_in;
   logic [2:0][NRM_W-1:0]   res_ff, res_in;

   logic [29:0]             sq_op;
   logic [61:0]             sum_nx;
   logic [34:0]             rem_sh;
   logic [34:0]             trial;
   logic                    root_bit;
   logic [30:0]             root_nx;
   logic                    div_ge;
   logic [14:0]             quo_nx;
   logic [NRM_W-1:0]        q_clip;
   logic [29:0]             next_mag;
   logic                    too_big;

   always_comb begin
      case (step_ff[1:0])
         2'd0:    sq_op = mag_ff[0][29:0];
         2'd1:    sq_op = mag_ff[1][29:0];
         2'd2:    sq_op = mag_ff[2][29:0];
         default: sq_op = '0;
      endcase
   end

   assign prod_in  = 60'(sq_op) * 60'(sq_op);
   assign sum_nx   = sum_ff + 62'(prod_ff);
   assign rem_sh   = {rem_ff, rad_ff[61:60]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign root_bit = (rem_sh >= trial);
   assign root_nx  = {root_ff[29:0], root_bit};
   assign div_ge   = (num_ff >= dsh_ff);
   assign quo_nx   = {quo_ff[13:0], div_ge};
   assign q_clip   = ({1'b0, quo_nx} > NRM_W'(Q14_ONE)) ? NRM_W'(Q14_ONE) : {1'b0, quo_nx};
   assign too_big  = |{mag_ff[0][VEC_W-1:30], mag_ff[1][VEC_W-1:30], mag_ff[2][VEC_W-1:30]};

   always_comb begin
      case (sel_ff)
         2'd0:    next_mag = mag_ff[1][29:0];
         default: next_mag = mag_ff[2][29:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      sel_in   = sel_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      case (state_ff)
         N_IDLE: begin
            if (req.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = req.vec[i][VEC_W-1];
                  mag_in[i] = req.vec[i][VEC_W-1] ? (~req.vec[i] + 1'b1) : req.vec[i];
               end
               zero_in  = 1'b0;
               state_in = N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (mag_ff == '0) begin
               zero_in  = 1'b1;
               state_in = N_DONE;
            end else if (too_big) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else begin
               step_in  = '0;
               sum_in   = '0;
               state_in = N_SQ;
            end
         end
         N_SQ: begin
            // the registered product seen here is that of step-1
            if (step_ff != '0) begin
               sum_in = sum_nx;
            end
            if (step_ff == 5'd3) begin
               rad_in   = sum_nx;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = N_SQRT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         N_SQRT: begin
            rem_in  = root_bit ? 33'(rem_sh - trial) : rem_sh[32:0];
            root_in = root_nx;
            rad_in  = rad_ff << 2;
            if (step_ff == 5'd30) begin
               sel_in   = '0;
               num_in   = {1'b0, mag_ff[0][29:0], 15'b0} + 46'(root_nx);
               dsh_in   = {root_nx, 15'b0};
               quo_in   = '0;
               step_in  = '0;
               state_in = N_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         N_DIV: begin
            num_in = div_ge ? (num_ff - dsh_ff) : num_ff;
            dsh_in = dsh_ff >> 1;
            quo_in = quo_nx;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd14) begin
               res_in[sel_ff] = neg_ff[sel_ff] ? (~q_clip + 1'b1) : q_clip;
               if (sel_ff == 2'd2) begin
                  state_in = N_DONE;
               end else begin
                  sel_in  = sel_ff + 1'b1;
                  num_in  = {1'b0, next_mag, 15'b0} + 46'(root_ff);
                  dsh_in  = {root_ff, 15'b0};
                  quo_in  = '0;
                  step_in = '0;
               end
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      sel_ff  <= sel_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   assign rsp.done = (state_ff == N_DONE);
   assign rsp.zero = zero_ff;
   assign rsp.comp = res_ff;

endmodule
`default_nettype wire

@@ test/tb_mesh_vertex_normal_averager.sv @@
`timescale 1ns / 100ps
`default_nettype none
// Vertex normal averager bench. Commands go in as beats on req_*, every
// command returns one beat on rsp_*. A local shadow of the position, normal
// and count tables predicts each result; rsp beats are matched in order.
module tb_mesh_vertex_normal_averager
   import mnva_pkg::*;
();

   typedef struct {
      logic signed [15:0] nx, ny, nz;
      logic [15:0]        cnt;
      status_type         st;
   } normal_beat_type;

   typedef struct {
      cmd_type            cmd;
      int                 a, b, c;
      int                 x, y, z;
      bit                 typed;      // row carries its own expected beat
      normal_beat_type    want;
   } cmd_row_type;

   localparam int NVERT     = VERTEX_COUNT_DEF;
   localparam int CYC_LIMIT = 6_000_000;
   localparam int NRANDOM   = 1880;
   localparam int DRAIN_CYC = 600;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // vert_a, vert_b, vert_c, pos_x, pos_y, pos_z, pad
   logic [1:0]            req_tuser;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // norm_x, norm_y, norm_z, seen_count
   logic [1:0]            rsp_tuser;   // status

   mesh_vertex_normal_averager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow tables
   logic signed [15:0] shadow_pos [NVERT][3];
   int                 shadow_nrm [NVERT][3];
   int unsigned        shadow_cnt [NVERT];
   bit                 pos_loaded [NVERT];
   int                 loaded_list[$];

   normal_beat_type    normals_due[$];
   int                 errors;
   int                 cycles;
   bit                 tail_phase;   // no idling on either side

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned bt;
      r  = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v = v - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   // Q1.14 unit vector; returns 0 for the zero vector
   function automatic bit to_unit(input longint c0, input longint c1, input longint c2,
                                  output int n0, output int n1, output int n2);
      longint          cv[3];
      longint unsigned m[3];
      longint unsigned mx, sum, len, q;
      int              s;
      int              r[3];
      cv[0] = c0; cv[1] = c1; cv[2] = c2;
      mx  = 0;
      sum = 0;
      s   = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (cv[i] < 0) ? longint'(-cv[i]) : longint'(cv[i]);
         if (m[i] > mx) mx = m[i];
      end
      n0 = 0; n1 = 0; n2 = 0;
      if (mx == 0) return 1'b0;
      while ((mx >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) begin
         m[i] = m[i] >> s;
         sum  = sum + m[i] * m[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 15) + len) / (2 * len);
         if (q > Q14_ONE) q = Q14_ONE;
         r[i] = (cv[i] < 0) ? -int'(q) : int'(q);
      end
      n0 = r[0]; n1 = r[1]; n2 = r[2];
      return 1'b1;
   endfunction

   function automatic void fold_face(input int v, input int f0, input int f1, input int f2);
      int unsigned n;
      int          r0, r1, r2;
      n = shadow_cnt[v];
      if (n < COUNT_MAX) n++;
      shadow_cnt[v] = n;
      if (n == 1) begin
         r0 = f0; r1 = f1; r2 = f2;
      end else if (!to_unit(longint'(shadow_nrm[v][0]) * longint'(n - 1) + f0,
                            longint'(shadow_nrm[v][1]) * longint'(n - 1) + f1,
                            longint'(shadow_nrm[v][2]) * longint'(n - 1) + f2,
                            r0, r1, r2)) begin
         // blend cancelled out: take the face normal
         r0 = f0; r1 = f1; r2 = f2;
      end
      shadow_nrm[v][0] = r0;
      shadow_nrm[v][1] = r1;
      shadow_nrm[v][2] = r2;
   endfunction

   function automatic normal_beat_type predict_normal(input cmd_row_type row);
      normal_beat_type rb;
      longint          d1[3], d2[3];
      int              f0, f1, f2;
      rb = '{nx: 0, ny: 0, nz: 0, cnt: 0, st: ST_OK};
      if (row.a >= NVERT || (row.cmd == CMD_TRI && (row.b >= NVERT || row.c >= NVERT))) begin
         if (row.cmd != CMD_CLEAR) begin
            rb.st = ST_RANGE;
            return rb;
         end
      end
      case (row.cmd)
         CMD_LOAD: begin
            shadow_pos[row.a][0] = row.x[15:0];
            shadow_pos[row.a][1] = row.y[15:0];
            shadow_pos[row.a][2] = row.z[15:0];
         end
         CMD_CLEAR: begin
            for (int i = 0; i < NVERT; i++) begin
               shadow_cnt[i] = 0;
               for (int k = 0; k < 3; k++) shadow_nrm[i][k] = 0;
            end
         end
         CMD_READ: begin
            rb.nx  = 16'(shadow_nrm[row.a][0]);
            rb.ny  = 16'(shadow_nrm[row.a][1]);
            rb.nz  = 16'(shadow_nrm[row.a][2]);
            rb.cnt = 16'(shadow_cnt[row.a]);
         end
         default: begin
            for (int k = 0; k < 3; k++) begin
               d1[k] = longint'(shadow_pos[row.b][k]) - longint'(shadow_pos[row.a][k]);
               d2[k] = longint'(shadow_pos[row.c][k]) - longint'(shadow_pos[row.a][k]);
            end
            if (!to_unit(d1[1] * d2[2] - d1[2] * d2[1],
                         d1[2] * d2[0] - d1[0] * d2[2],
                         d1[0] * d2[1] - d1[1] * d2[0], f0, f1, f2)) begin
               rb.st = ST_DEGEN;
            end else begin
               fold_face(row.a, f0, f1, f2);
               fold_face(row.b, f0, f1, f2);
               fold_face(row.c, f0, f1, f2);
               rb.nx = 16'(f0); rb.ny = 16'(f1); rb.nz = 16'(f2);
            end
         end
      endcase
      return rb;
   endfunction

   // ---------------------------------------------------------------------
   // command side
   // ---------------------------------------------------------------------
   task automatic send_cmd(input cmd_row_type row);
      normal_beat_type rb;
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.cmd;
      req_tdata  <= {2'b00, row.z[15:0], row.y[15:0], row.x[15:0],
                     row.c[9:0], row.b[9:0], row.a[9:0]};
      do @(posedge clock); while (!req_tready);
      // beat taken at this edge
      rb = predict_normal(row);
      if (row.typed) rb = row.want;
      normals_due.insert(normals_due.size(), rb);
      if (row.cmd == CMD_LOAD && !pos_loaded[row.a]) begin
         pos_loaded[row.a] = 1'b1;
         loaded_list.insert(loaded_list.size(), row.a);
      end
   endtask

   function automatic cmd_row_type mk(input cmd_type cmd, input int a, input int b,
                                      input int c, input int x, input int y, input int z);
      cmd_row_type row;
      row.cmd = cmd;
      row.a = a; row.b = b; row.c = c;
      row.x = x; row.y = y; row.z = z;
      row.typed = 1'b0;
      row.want  = '{nx: 0, ny: 0, nz: 0, cnt: 0, st: ST_OK};
      return row;
   endfunction

   function automatic cmd_row_type mk_typed(input cmd_row_type row, input status_type st);
      row.typed   = 1'b1;
      row.want.st = st;
      return row;
   endfunction

   function automatic int rand_coord();
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 65535) - 32768;
      return $urandom_range(0, 2047) - 1024;
   endfunction

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   cmd_row_type directed[$];

   function automatic void add_row(input cmd_row_type row);
      directed.insert(directed.size(), row);
   endfunction

   initial begin
      cmd_row_type row;
      int          sel;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_LOAD;
      reset      = 1'b1;
      tail_phase = 1'b0;
      errors     = 0;
      for (int i = 0; i < NVERT; i++) begin
         pos_loaded[i] = 1'b0;
         shadow_cnt[i] = 0;
         for (int k = 0; k < 3; k++) begin
            shadow_nrm[i][k] = 0;
            shadow_pos[i][k] = 0;
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // normal table reads back zero after reset
      add_row(mk_typed(mk(CMD_READ, 5, 0, 0, 0, 0, 0), ST_OK));
      // coordinate extremes, then three collinear points
      add_row(mk_typed(mk(CMD_LOAD, 0, 0, 0, -32768, -32768, -32768), ST_OK));
      add_row(mk_typed(mk(CMD_LOAD, 1, 0, 0, 32767, -32768, -32768), ST_OK));
      add_row(mk_typed(mk(CMD_LOAD, 2, 0, 0, -32768, 32767, -32768), ST_OK));
      add_row(mk_typed(mk(CMD_LOAD, 3, 0, 0, -32768, -32768, 32767), ST_OK));
      add_row(mk_typed(mk(CMD_LOAD, 1023, 1023, 1023, 32767, 32767, 32767), ST_OK));
      add_row(mk_typed(mk(CMD_LOAD, 4, 0, 0, 0, 0, 0), ST_OK));
      add_row(mk_typed(mk(CMD_LOAD, 5, 0, 0, 256, 0, 0), ST_OK));
      add_row(mk_typed(mk(CMD_LOAD, 6, 0, 0, 512, 0, 0), ST_OK));
      add_row(mk(CMD_TRI, 0, 1, 2, 0, 0, 0));
      // reversed winding: blends cancel, vertices take the face normal
      add_row(mk(CMD_TRI, 0, 2, 1, 0, 0, 0));
      add_row(mk(CMD_TRI, 0, 1, 3, 0, 0, 0));
      add_row(mk(CMD_TRI, 1023, 1, 2, 0, 0, 0));
      // collinear and repeated-vertex faces are skipped
      add_row(mk_typed(mk(CMD_TRI, 4, 5, 6, 0, 0, 0), ST_DEGEN));
      add_row(mk_typed(mk(CMD_TRI, 0, 0, 1, 0, 0, 0), ST_DEGEN));
      add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
      add_row(mk(CMD_READ, 1, 0, 0, 0, 0, 0));
      add_row(mk(CMD_READ, 1023, 0, 0, 0, 0, 0));
      add_row(mk_typed(mk(CMD_READ, 1022, 0, 0, 0, 0, 0), ST_OK));
      add_row(mk_typed(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), ST_OK));
      add_row(mk_typed(mk(CMD_READ, 0, 0, 0, 0, 0, 0), ST_OK));
      add_row(mk(CMD_TRI, 1, 2, 3, 0, 0, 0));
      add_row(mk(CMD_READ, 3, 0, 0, 0, 0, 0));
      foreach (directed[i]) send_cmd(directed[i]);

      for (int n = 0; n < NRANDOM; n++) begin
         if (n == NRANDOM / 2) begin
            // hold off until the block has drained
            req_tvalid <= 1'b0;
            wait (normals_due.size() == 0);
            @(posedge clock);
         end
         if (n == NRANDOM - 150) tail_phase = 1'b1;
         sel = $urandom_range(0, 99);
         if (sel < 25) begin
            row = mk(CMD_LOAD, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                                          : pick_loaded(),
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     rand_coord(), rand_coord(), rand_coord());
         end else if (sel < 27) begin
            row = mk(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
         end else if (sel < 50) begin
            row = mk(CMD_READ, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                          : pick_loaded(),
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     rand_coord(), rand_coord(), rand_coord());
         end else begin
            // triangles over loaded vertices only; some share a corner
            row = mk(CMD_TRI, pick_loaded(), pick_loaded(), pick_loaded(),
                     rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(0, 19) == 0) row.c = row.a;
         end
         send_cmd(row);
      end
      req_tvalid <= 1'b0;

      wait (normals_due.size() == 0);
      repeat (DRAIN_CYC) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // result side: random back-pressure and in-order check
   // ---------------------------------------------------------------------
   int stall_left;

   initial begin
      normal_beat_type due;
      logic [63:0]     got_d;
      logic [1:0]      got_u;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_d = rsp_tdata;
            got_u = rsp_tuser;
            if (normals_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat data=%h status=%0d", $time, got_d, got_u);
            end else begin
               due = normals_due.pop_front();
               if (got_d[15:0] !== due.nx || got_d[31:16] !== due.ny ||
                   got_d[47:32] !== due.nz || got_d[63:48] !== due.cnt ||
                   got_u !== due.st) begin
                  errors++;
                  $display("%0t: mismatch exp n=(%0d,%0d,%0d) cnt=%0d st=%0d", $time,
                           due.nx, due.ny, due.nz, due.cnt, due.st);
                  $display("%0t:          got n=(%0d,%0d,%0d) cnt=%0d st=%0d", $time,
                           $signed(got_d[15:0]), $signed(got_d[31:16]),
                           $signed(got_d[47:32]), got_d[63:48], got_u);
               end
            end
         end
         if (tail_phase) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYC_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire

@@ mesh_vertex_normal_averager.f @@
rtl/core/mnva_pkg.sv
rtl/core/mnva_ram.sv
rtl/core/mnva_norm.sv
rtl/core/mesh_vertex_normal_averager.sv
test/tb_mesh_vertex_normal_averager.sv
